/* design/hme_pkg.sv */
package hme_pkg;

  typedef struct packed {
    logic [9:0]  tick_rate;
    logic [15:0] impact_decay;
    logic [15:0] damage_decay;
    logic [15:0] smooth_alpha;
    logic [15:0] overall_strength;
    logic [15:0] impact_gain;
    logic [15:0] offroad_gain;
    logic [15:0] damage_scale;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [15:0]        health_now;
    logic [15:0]        health_max;
  } in_item_t;

  typedef struct packed {
    logic [15:0] strong_drive;
    logic [15:0] weak_drive;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic idle;
  } fq_stat_t;

  typedef struct packed {
    logic take;
    logic res_vld;
  } eng_stat_t;

  typedef enum logic [2:0] {
    REG_TICK_RATE,
    REG_IMPACT_DECAY,
    REG_DAMAGE_DECAY,
    REG_SMOOTH_ALPHA,
    REG_OVERALL_STRENGTH,
    REG_IMPACT_GAIN,
    REG_OFFROAD_GAIN,
    REG_DAMAGE_SCALE
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } eng_state_e;

  typedef enum logic [4:0] {
    SP_DX, SP_DY, SP_DZ, SP_VX, SP_VY, SP_VZ, SP_SQD, SP_SQS, SP_ACC,
    SP_IDEC, SP_IMP, SP_BUZ, SP_SPDF, SP_WEAK, SP_SM0, SP_SM1, SP_DDEC,
    SP_DROP, SP_DMG, SP_STR, SP_WK0, SP_WK1, SP_OS, SP_OW, SP_FIN
  } step_e;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_IDLE   = 1'b1;

  localparam logic [26:0] IMP_OFS  = 27'd15360;
  localparam logic [15:0] IMP_SPAN = 16'd61440;
  localparam logic [26:0] BUZ_OFS  = 27'd3072;
  localparam logic [15:0] BUZ_SPAN = 16'd12800;
  localparam logic [15:0] SPD_SPAN = 16'd5120;
  localparam logic [16:0] DMG_WEAK_FRAC = 17'd39322;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  // reciprocals of 15, 25 and 5 scaled by 2^28, 2^29 and 2^24
  localparam logic [24:0] IMP_RCP = 25'd17895698;
  localparam logic [24:0] BUZ_RCP = 25'd21474837;
  localparam logic [24:0] SPD_RCP = 25'd3355444;

  localparam logic [9:0]  TICK_RATE_RST        = 10'd60;
  localparam logic [15:0] IMPACT_DECAY_RST     = 16'd57345;
  localparam logic [15:0] DAMAGE_DECAY_RST     = 16'd61393;
  localparam logic [15:0] SMOOTH_ALPHA_RST     = 16'd21845;
  localparam logic [15:0] OVERALL_STRENGTH_RST = 16'd4096;
  localparam logic [15:0] IMPACT_GAIN_RST      = 16'd4096;
  localparam logic [15:0] OFFROAD_GAIN_RST     = 16'd4096;
  localparam logic [15:0] DAMAGE_SCALE_RST     = 16'd1280;

endpackage

/* design/haptic_motor_envelope_core.sv */
// channel   direction  handshake                 payload
// input     in         push / full               item_i (in_item_t)
// result    out        empty / pop               result_o (out_item_t)
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// a sample request passes through a take, 25 sequencer steps on one shared multiplier,
// two square roots, a division for a damage pulse below full scale, and a result
// an idle request goes from the take straight to the result; the input queue holds two requests
// reset clears the queue, all envelopes and history, and loads register defaults
// a result waits in the output register while the next request is processed
module haptic_motor_envelope_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hme_pkg::in_item_t   item_i,
  output logic                empty,
  input  logic                pop,
  output hme_pkg::out_item_t  result_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);
  import hme_pkg::*;

  cfg_t      cfg_q;
  in_item_t  head;
  fq_stat_t  fq_stat;
  eng_stat_t eng_stat;
  out_item_t eng_res, out_q;
  logic      out_vld_q;
  logic      res_rdy;

  assign res_rdy  = !out_vld_q || pop;
  assign empty    = !out_vld_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_rate        <= TICK_RATE_RST;
      cfg_q.impact_decay     <= IMPACT_DECAY_RST;
      cfg_q.damage_decay     <= DAMAGE_DECAY_RST;
      cfg_q.smooth_alpha     <= SMOOTH_ALPHA_RST;
      cfg_q.overall_strength <= OVERALL_STRENGTH_RST;
      cfg_q.impact_gain      <= IMPACT_GAIN_RST;
      cfg_q.offroad_gain     <= OFFROAD_GAIN_RST;
      cfg_q.damage_scale     <= DAMAGE_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_TICK_RATE:        cfg_q.tick_rate        <= cfg_wdata_i[9:0];
        REG_IMPACT_DECAY:     cfg_q.impact_decay     <= cfg_wdata_i;
        REG_DAMAGE_DECAY:     cfg_q.damage_decay     <= cfg_wdata_i;
        REG_SMOOTH_ALPHA:     cfg_q.smooth_alpha     <= cfg_wdata_i;
        REG_OVERALL_STRENGTH: cfg_q.overall_strength <= cfg_wdata_i;
        REG_IMPACT_GAIN:      cfg_q.impact_gain      <= cfg_wdata_i;
        REG_OFFROAD_GAIN:     cfg_q.offroad_gain     <= cfg_wdata_i;
        REG_DAMAGE_SCALE:     cfg_q.damage_scale     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hme_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .take_i(eng_stat.take), .head_o(head), .stat_o(fq_stat)
  );

  hme_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .head_i(head), .fq_i(fq_stat),
    .res_rdy_i(res_rdy), .stat_o(eng_stat), .res_o(eng_res)
  );

  always_ff @(posedge clk_i) begin
    if (eng_stat.res_vld && res_rdy) out_q <= eng_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_rdy) begin
      out_vld_q <= eng_stat.res_vld;
    end
  end

  a_eng_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.res_vld && !res_rdy |=> eng_stat.res_vld && $stable(eng_res))
    else $error("engine dropped a waiting result");

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.take |-> !fq_stat.empty)
    else $error("engine took from an empty queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> !fq_stat.empty)
    else $error("accepted request missing from queue");

endmodule

/* design/hme_front.sv */
module hme_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hme_pkg::in_item_t   item_i,
  input  logic                take_i,
  output hme_pkg::in_item_t   head_o,
  output hme_pkg::fq_stat_t   stat_o
);
  import hme_pkg::*;

  in_item_t   entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full   = (cnt_q == 2'd2);
  assign wr_en  = push && !full;
  assign rd_en  = take_i && (cnt_q != 2'd0);
  assign head_o = entry_q[rd_q];

  // classify the waiting request
  always_comb begin
    stat_o.empty = (cnt_q == 2'd0);
    stat_o.idle  = (entry_q[rd_q].opcode == OP_IDLE);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

/* design/hme_isqrt.sv */
module hme_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] rad_i,
  output logic        done_o,
  output logic [16:0] root_o
);
  logic [33:0] rad_q;
  logic [19:0] rem_q;
  logic [16:0] root_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [21:0] rem_t, trial;
  logic        ge;

  assign rem_t  = {rem_q, rad_q[33:32]};
  assign trial  = {3'b0, root_q, 2'b01};
  assign ge     = (rem_t >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q <= {rad_q[31:0], 2'b00};
      if (ge) begin
        rem_q  <= 20'(rem_t - trial);
        root_q <= {root_q[15:0], 1'b1};
      end else begin
        rem_q  <= rem_t[19:0];
        root_q <= {root_q[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd17;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/hme_div.sv */
module hme_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  logic [15:0] rem_q, lo_q, den_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [16:0] t;
  logic        ge;

  assign t      = {rem_q, lo_q[15]};
  assign ge     = (t >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = lo_q;

  // numerator high part is below the divisor, so sixteen quotient bits suffice
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[31:16];
      lo_q  <= num_i[15:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? 16'(t - {1'b0, den_q}) : t[15:0];
      lo_q  <= {lo_q[14:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd16;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/hme_engine.sv */
module hme_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hme_pkg::cfg_t       cfg_i,
  input  hme_pkg::in_item_t   head_i,
  input  hme_pkg::fq_stat_t   fq_i,
  input  logic                res_rdy_i,
  output hme_pkg::eng_stat_t  stat_o,
  output hme_pkg::out_item_t  res_o
);
  import hme_pkg::*;

  function automatic logic [15:0] abs17(input logic [16:0] d);
    logic [16:0] n;
    n = 17'(-d);
    return d[16] ? n[15:0] : d[15:0];
  endfunction

  function automatic logic [15:0] sat_q12(input logic [36:0] p);
    return (|p[36:28]) ? SAT16 : p[27:12];
  endfunction

  eng_state_e state_q, state_d;
  step_e      step_q, step_d;

  in_item_t    cur_q;
  out_item_t   res_q;
  logic [36:0] prod_q, prod_d;
  logic [33:0] dsq_q;
  logic [31:0] ssq_q;
  logic [16:0] dmag_q, spd_q;
  logic [26:0] accel_q;
  logic [15:0] dec_q, quo_q, buzz_q, wgt_q;
  logic [32:0] acc_q;
  logic [19:0] str_q, wk_q;
  logic [15:0] imp_env_q, bs_q, dmg_env_q;
  logic [15:0] pvx_q, pvy_q, pvz_q, ph_q;
  logic        vvalid_q, hvalid_q;

  logic [19:0] mul_a;
  logic [16:0] mul_b;
  logic [16:0] dx, dy, dz;
  logic [15:0] ph_use, drop;
  logic        sq_start, dv_start;
  logic [33:0] sq_rad;
  logic        sq_done, dv_done;
  logic [16:0] sq_root;
  logic [39:0] dv_num;
  logic [15:0] dv_den, dv_quo;
  logic [26:0] rv, roff, rx;
  logic [15:0] rden;
  logic        r_le, r_sat;
  logic [20:0] rnum;
  logic [45:0] rprod;
  logic [15:0] rquo, rres;
  logic [39:0] dnum;
  logic        dcond, dsat;
  logic [33:0] sm_sum;
  logic [15:0] st_max_lo;

  hme_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
    .done_o(sq_done), .root_o(sq_root)
  );

  hme_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // velocity change, zero on the first sample
  always_comb begin
    dx = {cur_q.vel_x[15], cur_q.vel_x} -
         (vvalid_q ? {pvx_q[15], pvx_q} : {cur_q.vel_x[15], cur_q.vel_x});
    dy = {cur_q.vel_y[15], cur_q.vel_y} -
         (vvalid_q ? {pvy_q[15], pvy_q} : {cur_q.vel_y[15], cur_q.vel_y});
    dz = {cur_q.vel_z[15], cur_q.vel_z} -
         (vvalid_q ? {pvz_q[15], pvz_q} : {cur_q.vel_z[15], cur_q.vel_z});
    ph_use = hvalid_q ? ph_q : cur_q.health_now;
    drop   = (ph_use > cur_q.health_now) ? 16'(ph_use - cur_q.health_now) : '0;
  end

  // ramp and clamp
  always_comb begin
    rv   = accel_q;
    roff = IMP_OFS;
    rden = IMP_SPAN;
    case (step_q)
      SP_BUZ: begin
        roff = BUZ_OFS;
        rden = BUZ_SPAN;
      end
      SP_SPDF: begin
        rv   = {10'b0, spd_q};
        roff = '0;
        rden = SPD_SPAN;
      end
      default: ;
    endcase
    rx    = rv - roff;
    r_le  = (rv <= roff);
    r_sat = (rx >= {11'b0, rden});
    // span division as a reciprocal multiply
    case (step_q)
      SP_BUZ: begin
        rnum  = {rx[13:0], 7'b0};
        rprod = 46'(rnum) * 46'(BUZ_RCP);
        rquo  = rprod[44:29];
      end
      SP_SPDF: begin
        rnum  = {2'b0, rx[12:0], 6'b0};
        rprod = 46'(rnum) * 46'(SPD_RCP);
        rquo  = rprod[39:24];
      end
      default: begin
        rnum  = {1'b0, rx[15:0], 4'b0};
        rprod = 46'(rnum) * 46'(IMP_RCP);
        rquo  = rprod[43:28];
      end
    endcase
    rres  = r_le ? '0 : (r_sat ? SAT16 : rquo);
    dnum  = {prod_q[31:0], 8'b0};
    dcond = (drop != '0) && (cur_q.health_max != '0) && (cfg_i.damage_scale != '0);
    dsat  = (dnum >= {8'b0, cur_q.health_max, 16'b0});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      SP_DX:   begin mul_a = {4'b0, abs17(dx)}; mul_b = {1'b0, abs17(dx)}; end
      SP_DY:   begin mul_a = {4'b0, abs17(dy)}; mul_b = {1'b0, abs17(dy)}; end
      SP_DZ:   begin mul_a = {4'b0, abs17(dz)}; mul_b = {1'b0, abs17(dz)}; end
      SP_VX: begin
        mul_a = {4'b0, abs17({cur_q.vel_x[15], cur_q.vel_x})};
        mul_b = {1'b0, abs17({cur_q.vel_x[15], cur_q.vel_x})};
      end
      SP_VY: begin
        mul_a = {4'b0, abs17({cur_q.vel_y[15], cur_q.vel_y})};
        mul_b = {1'b0, abs17({cur_q.vel_y[15], cur_q.vel_y})};
      end
      SP_VZ: begin
        mul_a = {4'b0, abs17({cur_q.vel_z[15], cur_q.vel_z})};
        mul_b = {1'b0, abs17({cur_q.vel_z[15], cur_q.vel_z})};
      end
      SP_ACC:  begin mul_a = {3'b0, dmag_q};  mul_b = {7'b0, cfg_i.tick_rate}; end
      SP_IDEC: begin mul_a = {4'b0, imp_env_q}; mul_b = {1'b0, cfg_i.impact_decay}; end
      SP_WEAK: begin mul_a = {4'b0, buzz_q};  mul_b = {1'b0, quo_q}; end
      SP_SM0: begin
        mul_a = {4'b0, bs_q};
        mul_b = 17'h10000 - {1'b0, cfg_i.smooth_alpha};
      end
      SP_SM1:  begin mul_a = {4'b0, wgt_q};   mul_b = {1'b0, cfg_i.smooth_alpha}; end
      SP_DDEC: begin mul_a = {4'b0, dmg_env_q}; mul_b = {1'b0, cfg_i.damage_decay}; end
      SP_DROP: begin mul_a = {4'b0, drop};    mul_b = {1'b0, cfg_i.damage_scale}; end
      SP_STR:  begin mul_a = {4'b0, imp_env_q}; mul_b = {1'b0, cfg_i.impact_gain}; end
      SP_WK0:  begin mul_a = {4'b0, bs_q};    mul_b = {1'b0, cfg_i.offroad_gain}; end
      SP_WK1:  begin mul_a = {4'b0, dmg_env_q}; mul_b = DMG_WEAK_FRAC; end
      SP_OS:   begin mul_a = str_q;           mul_b = {1'b0, cfg_i.overall_strength}; end
      SP_OW:   begin mul_a = wk_q;            mul_b = {1'b0, cfg_i.overall_strength}; end
      default: ;
    endcase
    prod_d    = 37'(mul_a) * 37'(mul_b);
    sm_sum    = {1'b0, acc_q} + {2'b0, prod_q[31:0]};
    st_max_lo = prod_q[31:16];
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    stat_o.take = 1'b0;
    sq_start    = 1'b0;
    sq_rad      = dsq_q;
    dv_start    = 1'b0;
    dv_num      = dnum;
    dv_den      = cur_q.health_max;
    case (state_q)
      ST_IDLE: begin
        if (!fq_i.empty) begin
          stat_o.take = 1'b1;
          step_d      = SP_DX;
          state_d     = fq_i.idle ? ST_DONE : ST_CALC;
        end
      end
      ST_CALC: begin
        step_d = step_e'(5'(step_q) + 5'd1);
        if (step_q == SP_SQD) begin
          sq_start = 1'b1;
          state_d  = ST_SQRT;
        end else if (step_q == SP_SQS) begin
          sq_start = 1'b1;
          sq_rad   = {2'b0, ssq_q};
          state_d  = ST_SQRT;
        end else if (step_q == SP_DMG && dcond && !dsat) begin
          dv_start = 1'b1;
          state_d  = ST_DIV;
        end else if (step_q == SP_FIN) begin
          step_d  = SP_DX;
          state_d = ST_DONE;
        end
      end
      ST_SQRT: begin
        if (sq_done) state_d = ST_CALC;
      end
      ST_DIV: begin
        if (dv_done) state_d = ST_CALC;
      end
      ST_DONE: begin
        if (res_rdy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    stat_o.res_vld = (state_q == ST_DONE);
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (stat_o.take) begin
      cur_q <= head_i;
      res_q <= '0;
    end
    if (state_q == ST_DIV && dv_done) quo_q <= dv_quo;
    if (state_q == ST_CALC) begin
      prod_q <= prod_d;
      case (step_q)
        SP_DY:   dsq_q <= {2'b0, prod_q[31:0]};
        SP_DZ:   dsq_q <= dsq_q + {2'b0, prod_q[31:0]};
        SP_VX:   dsq_q <= dsq_q + {2'b0, prod_q[31:0]};
        SP_VY:   ssq_q <= prod_q[31:0];
        SP_VZ:   ssq_q <= ssq_q + prod_q[31:0];
        SP_SQD:  ssq_q <= ssq_q + prod_q[31:0];
        SP_SQS:  dmag_q <= sq_root;
        SP_ACC:  spd_q <= sq_root;
        SP_IDEC: accel_q <= prod_q[26:0];
        SP_IMP: begin
          dec_q <= prod_q[31:16];
          quo_q <= rres;
        end
        SP_BUZ:  quo_q <= rres;
        SP_SPDF: begin
          buzz_q <= quo_q;
          quo_q  <= rres;
        end
        SP_SM0:  wgt_q <= prod_q[31:16];
        SP_SM1:  acc_q <= prod_q[32:0];
        SP_DROP: dec_q <= prod_q[31:16];
        SP_DMG: begin
          if (!dcond) quo_q <= '0;
          else if (dsat) quo_q <= SAT16;
        end
        SP_WK1:  wk_q <= prod_q[31:12];
        SP_OS:   if ({4'b0, st_max_lo} > wk_q) wk_q <= {4'b0, st_max_lo};
        SP_WK0:  str_q <= (prod_q[31:12] > {4'b0, dmg_env_q}) ? prod_q[31:12]
                                                             : {4'b0, dmg_env_q};
        SP_OW:   res_q.strong_drive <= sat_q12(prod_q);
        SP_FIN:  res_q.weak_drive <= sat_q12(prod_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= SP_DX;
      imp_env_q <= '0;
      bs_q      <= '0;
      dmg_env_q <= '0;
      vvalid_q  <= 1'b0;
      hvalid_q  <= 1'b0;
      pvx_q     <= '0;
      pvy_q     <= '0;
      pvz_q     <= '0;
      ph_q      <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (stat_o.take && fq_i.idle) begin
        imp_env_q <= '0;
        bs_q      <= '0;
        dmg_env_q <= '0;
        vvalid_q  <= 1'b0;
        hvalid_q  <= 1'b0;
      end
      if (state_q == ST_CALC) begin
        case (step_q)
          SP_BUZ:  imp_env_q <= (quo_q > dec_q) ? quo_q : dec_q;
          SP_DDEC: bs_q <= sm_sum[31:16];
          SP_DMG: begin
            pvx_q    <= cur_q.vel_x;
            pvy_q    <= cur_q.vel_y;
            pvz_q    <= cur_q.vel_z;
            ph_q     <= cur_q.health_now;
            vvalid_q <= 1'b1;
            hvalid_q <= 1'b1;
          end
          SP_STR:  dmg_env_q <= (quo_q > dec_q) ? quo_q : dec_q;
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/hme_checker.sv */
`timescale 1ns / 100ps
module hme_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  hme_pkg::in_item_t  item_i,
  input  logic               empty,
  input  logic               pop,
  input  hme_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import hme_pkg::*;

  logic [15:0] reg_q [8];
  logic [15:0] imp_env, buzz_sm, dmg_env, prev_hp;
  logic [15:0] prev_v [3];
  logic        vel_ok, hp_ok;
  out_item_t   drive_q [$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] clip16(input logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] ramp16(input logic [63:0] a, input logic [63:0] ofs,
                                         input logic [63:0] span);
    if (a <= ofs) return 16'd0;
    return clip16(((a - ofs) << 16) / span);
  endfunction

  task automatic predict_drive(input in_item_t it);
    logic signed [63:0] d, s;
    logic [63:0] dsq, ssq, accel, speed, strong_v, wk, t, dmg;
    logic [15:0] vin [3];
    logic [15:0] imp, buzz, spdf, weak_v, drop;
    out_item_t   r;
    if (it.opcode == OP_IDLE) begin
      imp_env = 0;
      buzz_sm = 0;
      dmg_env = 0;
      vel_ok  = 0;
      hp_ok   = 0;
      r = '0;
      drive_q.push_back(r);
      return;
    end
    vin[0] = it.vel_x;
    vin[1] = it.vel_y;
    vin[2] = it.vel_z;
    if (!vel_ok) begin
      prev_v = vin;
      vel_ok = 1;
    end
    dsq = 0;
    ssq = 0;
    for (int i = 0; i < 3; i++) begin
      d = $signed(vin[i]) - $signed(prev_v[i]);
      s = $signed(vin[i]);
      dsq += d * d;
      ssq += s * s;
    end
    prev_v = vin;
    accel = floor_sqrt(dsq) * reg_q[REG_TICK_RATE][9:0];
    speed = floor_sqrt(ssq);
    imp = ramp16(accel, 60 * 256, 240 * 256);
    imp_env = 16'((64'(imp_env) * reg_q[REG_IMPACT_DECAY]) >> 16);
    if (imp > imp_env) imp_env = imp;
    buzz = ramp16(accel, 12 * 256, 50 * 256);
    spdf = clip16((speed << 16) / (20 * 256));
    weak_v = 16'((64'(buzz) * spdf) >> 16);
    buzz_sm = 16'((64'(buzz_sm) * (65536 - 64'(reg_q[REG_SMOOTH_ALPHA]))
                   + 64'(weak_v) * reg_q[REG_SMOOTH_ALPHA]) >> 16);
    if (!hp_ok) begin
      prev_hp = it.health_now;
      hp_ok = 1;
    end
    drop = (prev_hp > it.health_now) ? prev_hp - it.health_now : 16'd0;
    prev_hp = it.health_now;
    dmg_env = 16'((64'(dmg_env) * reg_q[REG_DAMAGE_DECAY]) >> 16);
    if (drop >= 1 && it.health_max > 0 && reg_q[REG_DAMAGE_SCALE] > 0) begin
      dmg = clip16((64'(drop) * reg_q[REG_DAMAGE_SCALE] * 256) / it.health_max);
      if (dmg > dmg_env) dmg_env = dmg[15:0];
    end
    strong_v = (64'(imp_env) * reg_q[REG_IMPACT_GAIN]) >> 12;
    if (dmg_env > strong_v) strong_v = dmg_env;
    wk = (64'(buzz_sm) * reg_q[REG_OFFROAD_GAIN]) >> 12;
    t = (64'(dmg_env) * 39322) >> 16;
    if (t > wk) wk = t;
    r.strong_drive = clip16((strong_v * reg_q[REG_OVERALL_STRENGTH]) >> 12);
    r.weak_drive   = clip16((wk * reg_q[REG_OVERALL_STRENGTH]) >> 12);
    drive_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      reg_q[REG_TICK_RATE]        <= 16'(TICK_RATE_RST);
      reg_q[REG_IMPACT_DECAY]     <= IMPACT_DECAY_RST;
      reg_q[REG_DAMAGE_DECAY]     <= DAMAGE_DECAY_RST;
      reg_q[REG_SMOOTH_ALPHA]     <= SMOOTH_ALPHA_RST;
      reg_q[REG_OVERALL_STRENGTH] <= OVERALL_STRENGTH_RST;
      reg_q[REG_IMPACT_GAIN]      <= IMPACT_GAIN_RST;
      reg_q[REG_OFFROAD_GAIN]     <= OFFROAD_GAIN_RST;
      reg_q[REG_DAMAGE_SCALE]     <= DAMAGE_SCALE_RST;
      imp_env = 0;
      buzz_sm = 0;
      dmg_env = 0;
      prev_hp = 0;
      prev_v  = '{default: 16'd0};
      vel_ok  = 0;
      hp_ok   = 0;
      drive_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i)
        reg_q[cfg_idx_i] <= (cfg_idx_i == REG_TICK_RATE) ? {6'd0, cfg_wdata_i[9:0]}
                                                          : cfg_wdata_i;
      if (push && !full) predict_drive(item_i);
      if (pop && !empty) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = drive_q.pop_front();
          if (want.strong_drive !== result_o.strong_drive ||
              want.weak_drive !== result_o.weak_drive) begin
            $display("%0t: mismatch expected strong %0d weak %0d, got strong %0d weak %0d",
                     $time, want.strong_drive, want.weak_drive,
                     result_o.strong_drive, result_o.weak_drive);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= drive_q.size();
    end
  end
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
module tb;
  import hme_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  in_item_t    item_i = '0;
  logic        empty;
  logic        pop = 0;
  out_item_t   result_o;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  int          fail_count, pending;
  int          send_idle_pct, take_idle_pct;
  logic [15:0] health_run;

  haptic_motor_envelope_core dut (.*);

  hme_checker chk (
    .clk_i, .rst_ni, .push, .full, .item_i, .empty, .pop, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // receiver stalls at random
  always @(posedge clk_i) pop <= ($urandom_range(99) >= take_idle_pct);

  task automatic send_request(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk_i);
    end
    push   <= 1;
    item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    push <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic in_item_t motion_sample(input int mode);
    in_item_t it;
    it.opcode = ($urandom_range(39) == 0) ? OP_IDLE : OP_SAMPLE;
    case (mode)
      0: begin
        it.vel_x = 16'($urandom);
        it.vel_y = 16'($urandom);
        it.vel_z = 16'($urandom);
      end
      default: begin
        it.vel_x = 16'(int'($urandom_range(2047)) - 1024);
        it.vel_y = 16'(int'($urandom_range(2047)) - 1024);
        it.vel_z = 16'(int'($urandom_range(511)) - 256);
      end
    endcase
    if ($urandom_range(4) == 0) health_run = 16'($urandom);
    else if ($urandom_range(2) == 0) health_run = health_run - 16'($urandom_range(300));
    it.health_now = health_run;
    it.health_max = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1000));
    return it;
  endfunction

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    in_item_t it;
    send_idle_pct = 11;
    take_idle_pct = 57;
    health_run = 1000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, idle, first sample, rising health
    it = '0;
    send_request(it);
    it.vel_x = 16'sh7FFF; it.vel_y = 16'sh8000; it.vel_z = 16'sh7FFF;
    it.health_now = 16'hFFFF; it.health_max = 16'hFFFF;
    send_request(it);
    it.vel_x = 16'sh8000; it.vel_y = 16'sh7FFF; it.vel_z = 16'sh8000;
    it.health_now = 0; it.health_max = 1;
    send_request(it);
    it.health_now = 500; it.health_max = 0;
    send_request(it);
    it.health_now = 10; it.health_max = 16'hFFFF;
    send_request(it);
    it.opcode = OP_IDLE;
    send_request(it);
    it.opcode = OP_SAMPLE; it.vel_x = 100; it.vel_y = -100; it.vel_z = 0;
    send_request(it);
    it.vel_x = 2000; it.health_now = 5; it.health_max = 7;
    send_request(it);
    it.vel_x = -3000; it.health_now = 900;
    send_request(it);
    drain();

    write_reg(REG_TICK_RATE, 16'd0);
    write_reg(REG_DAMAGE_SCALE, 16'd0);
    for (int i = 0; i < 8; i++) send_request(motion_sample(i % 2));
    drain();
    write_reg(REG_TICK_RATE, 16'hFFFF);
    write_reg(REG_IMPACT_DECAY, 16'hFFFF);
    write_reg(REG_DAMAGE_DECAY, 16'hFFFF);
    write_reg(REG_SMOOTH_ALPHA, 16'hFFFF);
    write_reg(REG_OVERALL_STRENGTH, 16'hFFFF);
    write_reg(REG_IMPACT_GAIN, 16'hFFFF);
    write_reg(REG_OFFROAD_GAIN, 16'hFFFF);
    write_reg(REG_DAMAGE_SCALE, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_request(motion_sample(i % 2));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 11; take_idle_pct = 57; end
        1: begin send_idle_pct = 57; take_idle_pct = 11; end
        default: begin send_idle_pct = 0; take_idle_pct = 0; end
      endcase
      if (phase == 5) begin
        write_reg(REG_TICK_RATE, 16'd60);
        write_reg(REG_IMPACT_DECAY, 16'd0);
        write_reg(REG_DAMAGE_DECAY, 16'd0);
        write_reg(REG_SMOOTH_ALPHA, 16'd0);
        write_reg(REG_OVERALL_STRENGTH, 16'd0);
        write_reg(REG_IMPACT_GAIN, 16'd0);
        write_reg(REG_OFFROAD_GAIN, 16'd0);
        write_reg(REG_DAMAGE_SCALE, 16'd0);
      end else if (phase > 0) begin
        write_reg(REG_TICK_RATE, 16'($urandom_range(1000, 10)));
        write_reg(REG_IMPACT_DECAY, 16'($urandom));
        write_reg(REG_DAMAGE_DECAY, 16'($urandom));
        write_reg(REG_SMOOTH_ALPHA, 16'($urandom));
        write_reg(REG_OVERALL_STRENGTH, 16'($urandom_range(8192)));
        write_reg(REG_IMPACT_GAIN, 16'($urandom_range(16384)));
        write_reg(REG_OFFROAD_GAIN, 16'($urandom_range(16384)));
        write_reg(REG_DAMAGE_SCALE, 16'($urandom_range(4000)));
      end
      for (int i = 0; i < 320; i++)
        send_request(motion_sample(($urandom_range(4) == 0) ? 0 : 1));
      drain();
    end

    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

/* filelist.f */
design/hme_pkg.sv
design/hme_front.sv
design/hme_isqrt.sv
design/hme_div.sv
design/hme_engine.sv
design/haptic_motor_envelope_core.sv
test/hme_checker.sv
test/tb.sv
